@@ sv/local_maximum_detector_2d_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the local maximum detector.
// ---------------------------------------------------------------------------
`ifndef LOCAL_MAXIMUM_DETECTOR_2D_DEFINES_SVH
`define LOCAL_MAXIMUM_DETECTOR_2D_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LMD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LMD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lmd_pkg.sv @@
// ---------------------------------------------------------------------------
// lmd_pkg
// Shared types and constants of the local maximum detector.
// ---------------------------------------------------------------------------
package lmd_pkg;

  localparam int MAX_WIDTH       = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int COL_BITS        = $clog2(MAX_WIDTH);
  localparam int ROW_BITS        = 12;
  localparam int HEIGHT_LIMIT    = 4096;
  localparam int WIDTH_CFG_BITS  = 11;
  localparam int HEIGHT_CFG_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int MIN_SIZE        = 3;
  localparam int RESET_SIZE      = 5;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS  = QUEUE_PTR_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [ROW_BITS-1:0]           row_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // One line buffer entry: the column's sample two rows up and one row up.
  typedef struct packed {
    sample_t upper;
    sample_t middle;
  } line_entry_t;

  typedef struct packed {
    row_t row;
    col_t col;
    logic is_local_max;
    logic last_of_frame;
  } result_t;

  // Results pushed by one input transaction.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

@@ sv/lmd_line_ram.sv @@
// ---------------------------------------------------------------------------
// lmd_line_ram
// Line buffer memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module lmd_line_ram (
  input  logic                clk,
  input  logic                wr_en,
  input  lmd_pkg::col_t       wr_addr,
  input  lmd_pkg::line_entry_t wr_data,
  input  logic                rd_en,
  input  lmd_pkg::col_t       rd_addr,
  output lmd_pkg::line_entry_t rd_data
);
  import lmd_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/lmd_result_queue.sv @@
// ---------------------------------------------------------------------------
// lmd_result_queue
// Small queue taking up to two results per cycle, giving one unless stalled.
// ---------------------------------------------------------------------------
module lmd_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  lmd_pkg::push_t   push,
  input  lmd_pkg::result_t first_data,
  input  lmd_pkg::result_t second_data,
  output logic             near_full,
  output logic             out_valid,
  input  logic             out_stall,
  output lmd_pkg::result_t head
);
  import lmd_pkg::*;

  result_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic [QUEUE_CNT_BITS-1:0] count_next;
  logic                      pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = slots[rd_ptr];
  // Room for two is needed before the next transaction can be taken.
  assign near_full = (count > QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + QUEUE_CNT_BITS'(push.first) + QUEUE_CNT_BITS'(push.second)
                 - QUEUE_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push.first) begin
        wr_ptr <= wr_ptr + (push.second ? QUEUE_PTR_BITS'(2) : QUEUE_PTR_BITS'(1));
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= first_data;
    end
    if (push.second) begin
      slots[wr_ptr + QUEUE_PTR_BITS'(1)] <= second_data;
    end
  end

endmodule

@@ sv/local_maximum_detector_2d.sv @@
// ---------------------------------------------------------------------------
// local_maximum_detector_2d
// Four-neighbor local maximum detection over a raster-order pixel stream.
// ---------------------------------------------------------------------------
// A pixel's flag is produced when the pixel below it is accepted; it is
// registered in the result queue and offered on the result port from there.
// Throughput: one pixel per cycle while the result queue has room; in the last
// row of a frame each pixel gives two results, and the one result port stalls it.
// Reset clears the counters, the result queue and sets both sizes to 5; the
// line buffer memory is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module local_maximum_detector_2d (
  input  logic                clk,
  input  logic                rst,
  // Configuration write port.
  input  logic                cfg_write_en,
  input  lmd_pkg::reg_index_t cfg_index,
  input  logic [lmd_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // Pixel channel.
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  lmd_pkg::sample_t    pixel_value,
  // Result channel.
  output logic                result_valid,
  input  logic                result_stall,
  output lmd_pkg::row_t       out_row,
  output lmd_pkg::col_t       out_col,
  output logic                is_local_max,
  output logic                last_of_frame
);
  import lmd_pkg::*;

  // Frame sizes are stored already clamped to their legal ranges.
  function automatic logic [WIDTH_CFG_BITS-1:0] clamp_width(
    input logic [CFG_DATA_BITS-1:0] value
  );
    logic [WIDTH_CFG_BITS-1:0] v;
    v = value[WIDTH_CFG_BITS-1:0];
    if (v < WIDTH_CFG_BITS'(MIN_SIZE)) begin
      return WIDTH_CFG_BITS'(MIN_SIZE);
    end else if (v > WIDTH_CFG_BITS'(MAX_WIDTH)) begin
      return WIDTH_CFG_BITS'(MAX_WIDTH);
    end
    return v;
  endfunction

  function automatic logic [HEIGHT_CFG_BITS-1:0] clamp_height(
    input logic [CFG_DATA_BITS-1:0] value
  );
    logic [HEIGHT_CFG_BITS-1:0] v;
    v = value[HEIGHT_CFG_BITS-1:0];
    if (v < HEIGHT_CFG_BITS'(MIN_SIZE)) begin
      return HEIGHT_CFG_BITS'(MIN_SIZE);
    end else if (v > HEIGHT_CFG_BITS'(HEIGHT_LIMIT)) begin
      return HEIGHT_CFG_BITS'(HEIGHT_LIMIT);
    end
    return v;
  endfunction

  logic [WIDTH_CFG_BITS-1:0]  frame_width;
  logic [HEIGHT_CFG_BITS-1:0] frame_height;
  row_t                       row_count;
  col_t                       col_count;

  // Sliding window over the row above the incoming pixel. The line buffer
  // entry of the current column sits in cur_entry, the entry one column to
  // the right comes out of the memory read register, and the left neighbor
  // is the previous center. Column 0's fresh entry is kept aside so the next
  // row can start without a second read port.
  line_entry_t cur_entry;
  line_entry_t col0_entry;
  line_entry_t rd_entry;
  line_entry_t wr_entry;
  sample_t     left_sample;

  logic    accept;
  logic    last_row;
  logic    last_col;
  logic    interior;
  logic    flag;
  col_t    rd_addr;
  push_t   push;
  result_t first_res;
  result_t second_res;
  result_t head;
  logic    queue_near_full;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = queue_near_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_CFG_BITS'(RESET_SIZE);
      frame_height <= HEIGHT_CFG_BITS'(RESET_SIZE);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= clamp_width(cfg_data);
        REG_FRAME_HEIGHT: frame_height <= clamp_height(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    last_row = (HEIGHT_CFG_BITS'(row_count) + HEIGHT_CFG_BITS'(1)) >= frame_height;
    last_col = (WIDTH_CFG_BITS'(col_count) + WIDTH_CFG_BITS'(1)) >= frame_width;
    // The pixel judged is one row up; it is interior when that row is not the
    // first or last and the column is not the first or last.
    interior = (row_count >= ROW_BITS'(2))
            && ((HEIGHT_CFG_BITS'(row_count) + HEIGHT_CFG_BITS'(1)) <= frame_height)
            && (col_count != '0)
            && ((WIDTH_CFG_BITS'(col_count) + WIDTH_CFG_BITS'(2)) <= frame_width);
    flag = interior
        && (cur_entry.middle >= left_sample)
        && (cur_entry.middle >= rd_entry.middle)
        && (cur_entry.middle >= cur_entry.upper)
        && (cur_entry.middle >= pixel_value);

    wr_entry.upper  = cur_entry.middle;
    wr_entry.middle = pixel_value;

    // Prefetch the right neighbor of the next transaction's column. A read
    // never hits the entry written in the same cycle, and the entry it reads
    // is not written again before it is used, so no forwarding is needed.
    rd_addr = last_col ? COL_BITS'(1) : col_count + COL_BITS'(2);

    first_res.row           = row_count - ROW_BITS'(1);
    first_res.col           = col_count;
    first_res.is_local_max  = flag;
    first_res.last_of_frame = 1'b0;

    // The bottom row is border: its own flag is always clear.
    second_res.row           = row_count;
    second_res.col           = col_count;
    second_res.is_local_max  = 1'b0;
    second_res.last_of_frame = last_col;

    push.first  = accept && (row_count != '0);
    push.second = push.first && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_BITS'(1);
      end else begin
        col_count <= col_count + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_sample <= cur_entry.middle;
      cur_entry   <= last_col ? col0_entry : rd_entry;
      if (col_count == '0) begin
        col0_entry <= wr_entry;
      end
    end
  end

  lmd_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_count),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  lmd_result_queue u_result_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_data  (first_res),
    .second_data (second_res),
    .near_full   (queue_near_full),
    .out_valid   (result_valid),
    .out_stall   (result_stall),
    .head        (head)
  );

  assign out_row       = head.row;
  assign out_col       = head.col;
  assign is_local_max  = head.is_local_max;
  assign last_of_frame = head.last_of_frame;

endmodule

@@ sv/lmd_checker.sv @@
// ---------------------------------------------------------------------------
// lmd_checker
// Port-level checks of the local maximum detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "local_maximum_detector_2d_defines.svh"

module lmd_checker (
  input logic          clk,
  input logic          rst,
  input logic          result_valid,
  input logic          result_stall,
  input lmd_pkg::row_t out_row,
  input lmd_pkg::col_t out_col,
  input logic          is_local_max,
  input logic          last_of_frame
);
  import lmd_pkg::*;

  // A stalled result transaction stays offered unchanged.
  `LMD_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid && $stable(out_row) && $stable(out_col) && $stable(is_local_max) && $stable(last_of_frame), "stalled result changed")

  // The top row and the left column are border and never flagged.
  `LMD_ASSERT_NOW(a_border_clear, clk, rst, result_valid && (out_row == '0 || out_col == '0), !is_local_max, "border pixel flagged")

  // The frame's final pixel lies on the bottom border, past the first row.
  `LMD_ASSERT_NOW(a_last_is_border, clk, rst, result_valid && last_of_frame, !is_local_max && out_row != '0, "bad final pixel result")

  // The last column of a frame is at least column 2.
  `LMD_ASSERT_NOW(a_last_col_range, clk, rst, result_valid && last_of_frame, out_col >= COL_BITS'(2), "final pixel column too small")

endmodule

bind local_maximum_detector_2d lmd_checker u_lmd_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .out_row       (out_row),
  .out_col       (out_col),
  .is_local_max  (is_local_max),
  .last_of_frame (last_of_frame)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-neighbor local maximum detector.
// A short directed table covers the reset frame size, the first row, the
// border flags, ties, a height change in the middle of a frame and the size
// clamps. Random frames follow, checked against a behavioral predictor,
// under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module tb_top;
  import lmd_pkg::*;

  // Receiver hold-off length, the pause after the last result before a
  // register write, the watchdog limit and the number of detailed reports.
  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int STUCK_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;
  localparam int PHASE_ITEMS   = 150;
  // Pixels offered in the first row of the widest frame before it is cut.
  localparam int WIDE_PIXELS   = 40;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    STEP_PIXEL,
    STEP_WIDTH,
    STEP_HEIGHT
  } step_kind_t;

  // One row of the directed table. A pinned pixel row carries the flags it
  // must produce, typed in by hand; other rows are checked by the predictor.
  typedef struct packed {
    step_kind_t kind;
    logic [15:0] data;
    logic        pinned;
    logic [1:0]  pin_cnt;
    result_t     pin_a;
    result_t     pin_b;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  reg_index_t  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  sample_t     pixel_value = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  row_t        out_row;
  col_t        out_col;
  logic        is_local_max;
  logic        last_of_frame;

  // Typed-in flags travel beside the pixel payload so that the monitor sees
  // them at the same edge as the pixel transaction.
  logic        pin_use = 1'b0;
  logic [1:0]  pin_cnt = 2'd0;
  result_t     pin_a = '0;
  result_t     pin_b = '0;

  // Idling controls, set per phase by the stimulus process.
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;

  // Predictor state: the two line buffers, the raster position and the
  // frame size registers, all as the block holds them after reset.
  sample_t     upper_px [MAX_WIDTH];
  sample_t     middle_px[MAX_WIDTH];
  row_t        px_row = '0;
  col_t        px_col = '0;
  logic [WIDTH_CFG_BITS-1:0]  width_reg = WIDTH_CFG_BITS'(RESET_SIZE);
  logic [HEIGHT_CFG_BITS-1:0] height_reg = HEIGHT_CFG_BITS'(RESET_SIZE);

  // Flags still owed by the block, oldest first.
  result_t     pending_flags[$];
  int          flag_errors = 0;
  int          stuck_cycles = 0;

  local_maximum_detector_2d uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .is_local_max (is_local_max),
    .last_of_frame(last_of_frame)
  );

  always #10 clk = ~clk;

  // The size registers take any value; the block stores them already clamped
  // to the supported range, and the predictor clamps them here when it uses them.
  function automatic int unsigned eff_width();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < MIN_SIZE) return MIN_SIZE;
    if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return height_reg;
  endfunction

  // Pixels still to come before the raster position wraps to the top left.
  // A column at or past the last one ends the row on the next pixel.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned cols;
    int unsigned rows;
    w = eff_width();
    h = eff_height();
    cols = (px_col + 1 >= w) ? 1 : w - px_col;
    rows = (px_row + 1 >= h) ? 0 : h - px_row - 1;
    return cols + rows * w;
  endfunction

  // Works out the flags that one accepted pixel causes and advances the
  // predictor. The pixel at (r, c) completes the neighborhood of (r-1, c),
  // so that flag comes out now. In the bottom row the pixel also gets its
  // own flag, which is always clear since it lies on the border.
  function automatic int predict_flags(input sample_t x, output result_t above,
                                       output result_t own);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    bit          last_row;
    bit          last_col;
    sample_t     centre;
    w = eff_width();
    h = eff_height();
    r = px_row;
    c = px_col;
    last_row = (r + 1 >= h);
    last_col = (c + 1 >= w);
    above = '0;
    own = '0;
    predict_flags = 0;
    if (r >= 1) begin
      above.row = row_t'(r - 1);
      above.col = col_t'(c);
      // The left neighbor has already moved to the upper line in this row.
      if (r >= 2 && r + 1 <= h && c >= 1 && c + 2 <= w) begin
        centre = middle_px[c];
        above.is_local_max = centre >= upper_px[c - 1] && centre >= middle_px[c + 1] &&
                             centre >= upper_px[c] && centre >= x;
      end
      predict_flags = 1;
    end
    upper_px[c] = middle_px[c];
    middle_px[c] = x;
    if (last_row && r >= 1) begin
      own.row = row_t'(r);
      own.col = col_t'(c);
      own.last_of_frame = last_col;
      predict_flags = 2;
    end
    if (last_col) begin
      px_col = '0;
      px_row = last_row ? row_t'(0) : row_t'(r + 1);
    end else begin
      px_col = col_t'(c + 1);
    end
  endfunction

  function automatic result_t res(int r, int c, bit f, bit l);
    result_t v;
    v.row = row_t'(r);
    v.col = col_t'(c);
    v.is_local_max = f;
    v.last_of_frame = l;
    return v;
  endfunction

  function automatic step_t step(step_kind_t kind, logic [15:0] data, bit pinned,
                                 logic [1:0] cnt, result_t a, result_t b);
    step_t s;
    s.kind = kind;
    s.data = data;
    s.pinned = pinned;
    s.pin_cnt = cnt;
    s.pin_a = a;
    s.pin_b = b;
    return s;
  endfunction

  function automatic void report_flag_error(string why, result_t e, result_t g);
    flag_errors++;
    if (flag_errors <= REPORT_LIMIT)
      $display("%0t: %s: expected row %0d col %0d max %0b last %0b, %s",
               $realtime, why, e.row, e.col, e.is_local_max, e.last_of_frame,
               $sformatf("got row %0d col %0d max %0b last %0b",
                         g.row, g.col, g.is_local_max, g.last_of_frame));
  endfunction

  // Monitor. Everything is sampled at the rising edge, before the block's
  // own updates land. Results are checked before the new pixel's flags are
  // queued, since no flag can leave in the cycle its pixel is taken.
  always @(posedge clk) begin : monitor
    result_t above;
    result_t own;
    result_t got;
    int      produced;
    bit      moved;
    if (!rst) begin
      moved = 1'b0;
      if (cfg_write_en) begin
        moved = 1'b1;
        if (cfg_index == REG_FRAME_WIDTH)
          width_reg = cfg_data[WIDTH_CFG_BITS-1:0];
        else if (cfg_index == REG_FRAME_HEIGHT)
          height_reg = cfg_data[HEIGHT_CFG_BITS-1:0];
      end
      if (result_valid && !result_stall) begin
        moved = 1'b1;
        got.row = out_row;
        got.col = out_col;
        got.is_local_max = is_local_max;
        got.last_of_frame = last_of_frame;
        if (pending_flags.size() == 0) begin
          report_flag_error("flag with none pending", '0, got);
        end else begin
          above = pending_flags.pop_front();
          if (got.row !== above.row || got.col !== above.col ||
              got.is_local_max !== above.is_local_max ||
              got.last_of_frame !== above.last_of_frame)
            report_flag_error("flag mismatch", above, got);
        end
      end
      if (pixel_valid && !pixel_stall) begin
        moved = 1'b1;
        produced = predict_flags(pixel_value, above, own);
        if (pin_use) begin
          if (pin_cnt >= 2'd1) pending_flags.push_back(pin_a);
          if (pin_cnt == 2'd2) pending_flags.push_back(pin_b);
        end else begin
          if (produced >= 1) pending_flags.push_back(above);
          if (produced == 2) pending_flags.push_back(own);
        end
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  // Watchdog: too long without any transaction means the block is hung.
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver. It stalls at random at the phase's rate, or holds off for a
  // whole stretch when asked, counting that stretch here.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one pixel, with random idle cycles ahead of it, and returns at
  // the rising edge where the transaction takes place.
  task automatic send_pixel(sample_t v, bit pinned, logic [1:0] cnt, result_t a,
                            result_t b);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= v;
    pin_use <= pinned;
    pin_cnt <= cnt;
    pin_a <= a;
    pin_b <= b;
    do @(posedge clk); while (pixel_stall);
  endtask

  // Random pixels mix full-range values, the two extremes and a narrow band
  // around zero, so that ties between neighbors come up often.
  task automatic send_random(int unsigned n);
    sample_t v;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1:    v = $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
        2, 3, 4: v = sample_t'(16'($urandom_range(4)) - 16'd2);
        default: v = sample_t'($urandom);
      endcase
      send_pixel(v, 1'b0, 2'd0, '0, '0);
    end
  endtask

  // Stops offering pixels and waits until every owed flag has come out,
  // then pauses for pixels that owe no flag.
  task automatic settle();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] d);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Whole frames of random pixels, starting and ending at a frame boundary.
  // Most frames run at one size; some get a new size at the boundary, and a
  // few change size part way through. A width change in the middle of a
  // frame only ever narrows it, so no unwritten line entry is ever read.
  task automatic run_frames(int unsigned budget);
    int unsigned sent;
    int unsigned total;
    int unsigned k;
    logic [CFG_DATA_BITS-1:0] d;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(1, eff_width() * eff_height() - 1);
        send_random(k);
        settle();
        if (eff_width() > MIN_SIZE && $urandom_range(1))
          write_reg(REG_FRAME_WIDTH, CFG_DATA_BITS'($urandom_range(0, eff_width() - 1)));
        else
          write_reg(REG_FRAME_HEIGHT, CFG_DATA_BITS'($urandom_range(0, 10)));
        total = pixels_to_frame_end();
        send_random(total);
        sent += k + total;
      end else begin
        if ($urandom_range(1)) begin
          settle();
          // The two top data bits are beyond the width register and dropped.
          d = {2'($urandom_range(3)),
               11'($urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(12))};
          write_reg(REG_FRAME_WIDTH, d);
          d = CFG_DATA_BITS'($urandom_range(9) == 0 ? $urandom_range(20) : $urandom_range(8));
          write_reg(REG_FRAME_HEIGHT, d);
        end
        total = eff_width() * eff_height();
        send_random(total);
        sent += total;
      end
    end
  endtask

  initial begin
    step_t directed[$];

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Frame at the reset size of five by five. The first row owes nothing,
    // the second gives the top border flags. Then the height is dropped to
    // zero, which acts as three, so the third row becomes the bottom row.
    directed.push_back(step(STEP_PIXEL, 16'h8000, 1, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0000, 1, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 1, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0000, 1, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h8000, 1, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0000, 1, 1, res(0, 0, 0, 0), '0));
    directed.push_back(step(STEP_PIXEL, 16'h0000, 1, 1, res(0, 1, 0, 0), '0));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 1, 1, res(0, 2, 0, 0), '0));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 1, 1, res(0, 3, 0, 0), '0));
    directed.push_back(step(STEP_PIXEL, 16'h8000, 1, 1, res(0, 4, 0, 0), '0));
    directed.push_back(step(STEP_HEIGHT, 16'h0000, 0, 0, '0, '0));
    // Column one sits below the maximum on its right. Columns two and three
    // form a plateau of the largest value, and ties count as a maximum.
    directed.push_back(step(STEP_PIXEL, 16'h1111, 1, 2, res(1, 0, 0, 0), res(2, 0, 0, 0)));
    directed.push_back(step(STEP_PIXEL, 16'h8000, 1, 2, res(1, 1, 0, 0), res(2, 1, 0, 0)));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 1, 2, res(1, 2, 1, 0), res(2, 2, 0, 0)));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 1, 2, res(1, 3, 1, 0), res(2, 3, 0, 0)));
    directed.push_back(step(STEP_PIXEL, 16'hFFFF, 1, 2, res(1, 4, 0, 0), res(2, 4, 0, 1)));
    // Width two with junk in the upper data bits acts as three: the smallest
    // frame, whose center loses to its right neighbor by one.
    directed.push_back(step(STEP_WIDTH, 16'h1802, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0001, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0000, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'hFFFF, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0005, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0004, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0005, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h7FFF, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h8000, 0, 0, '0, '0));
    directed.push_back(step(STEP_PIXEL, 16'h0003, 0, 0, '0, '0));

    foreach (directed[i]) begin
      case (directed[i].kind)
        STEP_WIDTH: begin
          settle();
          write_reg(REG_FRAME_WIDTH, directed[i].data[CFG_DATA_BITS-1:0]);
        end
        STEP_HEIGHT: begin
          settle();
          write_reg(REG_FRAME_HEIGHT, directed[i].data[CFG_DATA_BITS-1:0]);
        end
        default: begin
          send_pixel(sample_t'(directed[i].data), directed[i].pinned, directed[i].pin_cnt,
                     directed[i].pin_a, directed[i].pin_b);
        end
      endcase
    end

    // Random phases: no idling, an idle sender, a stalling receiver, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 72; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      if (phase == 0) begin
        // The receiver holds off while a whole small frame is offered, so
        // the result queue fills and the pixel input has to stall.
        settle();
        hold_req = 1'b1;
        send_random(eff_width() * eff_height());
        // A width above the limit and the largest height the register holds
        // act as the widest and tallest frame. The first row runs well past
        // the old width, then the frame is cut down to three by three.
        settle();
        write_reg(REG_FRAME_WIDTH, 13'h07FF);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        send_random(WIDE_PIXELS);
        settle();
        write_reg(REG_FRAME_WIDTH, 13'h0003);
        write_reg(REG_FRAME_HEIGHT, 13'h0003);
        send_random(pixels_to_frame_end());
      end
      run_frames(PHASE_ITEMS);
    end

    settle();
    if (flag_errors == 0 && pending_flags.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ local_maximum_detector_2d.f @@
+incdir+sv
sv/lmd_pkg.sv
sv/lmd_line_ram.sv
sv/lmd_result_queue.sv
sv/local_maximum_detector_2d.sv
sv/lmd_checker.sv
verif/tb_top.sv
